[hw/rtl/steepest_descent_solver_defines.svh]
`ifndef STEEPEST_DESCENT_SOLVER_DEFINES_SVH
`define STEEPEST_DESCENT_SOLVER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sds_chk: same-cycle check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sds_chk: next-cycle check failed");

`endif

[hw/rtl/sds_pkg.sv]
`default_nettype none

package sds_pkg;

    localparam int MAX_UNKNOWNS = 64;
    localparam int IDX_W        = $clog2(MAX_UNKNOWNS);
    localparam int SIZE_W       = IDX_W + 1;
    localparam int MAT_AW       = 2 * IDX_W;
    localparam int DATA_W       = 32;
    localparam int ACC_W        = 64;
    localparam int TOL_W        = 40;
    localparam int ITER_W       = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int STAT_W       = 2;
    localparam int FRAC_BITS    = 16;
    localparam int DIV_STEPS    = ACC_W + FRAC_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int DRAIN_CYC    = 5;
    localparam int DRAIN_W      = $clog2(DRAIN_CYC);

    localparam logic [SIZE_W-1:0] SIZE_RESET  = SIZE_W'(MAX_UNKNOWNS);
    localparam logic [ITER_W-1:0] LIMIT_RESET = 16'd60000;
    localparam logic [TOL_W-1:0]  TOL_RESET   = 40'd1;

    typedef enum logic [1:0] {
        OP_WR_MAT = 2'd0,
        OP_WR_RHS = 2'd1,
        OP_START  = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_CONV  = 2'd0,
        ST_LIMIT = 2'd1,
        ST_BREAK = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE  = 2'd0,
        CFG_LIMIT = 2'd1,
        CFG_TOL   = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_MVX,
        PH_MVR,
        PH_DOT,
        PH_UPD,
        PH_EMIT,
        PH_CLR
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_MVX,
        S_DRX,
        S_MVR,
        S_DRR,
        S_DOT,
        S_DRD,
        S_CHK,
        S_DIV,
        S_UPD,
        S_DRU,
        S_DEC,
        S_EMRD,
        S_EMWT,
        S_EMOUT
    } t_state;

    typedef struct packed {
        logic             valid;
        t_phase           phase;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic             first;
        logic             last;
        logic             wr_mat;
        logic             wr_rhs;
        logic             div_go;
        logic             load_out;
        logic [TOL_W-1:0] tol;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
        logic rr_le_tol;
        logic div_done;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/sds_if.sv]
`default_nettype none

interface sds_in_if import sds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input value,
                    output ready);
endinterface

interface sds_out_if import sds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] solution;
    logic                     last;
    logic [STAT_W-1:0]        status;
    logic [ITER_W-1:0]        iterations;

    modport source (output valid, output index, output solution, output last,
                    output status, output iterations, input ready);
    modport sink   (input valid, input index, input solution, input last,
                    input status, input iterations, output ready);
endinterface

interface sds_cfg_if import sds_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TOL_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/sds_div.sv]
`default_nettype none

module sds_div import sds_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire logic [ACC_W-1:0]  i_num,
    input  wire logic [ACC_W-1:0]  i_den,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quo,
    output logic                   o_ovf
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0]     r_num;
    logic [ACC_W-1:0]     r_den;
    logic [ACC_W-1:0]     r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic                 r_ovf;

    logic             w_in;
    logic [ACC_W-1:0] w_sh;
    logic             w_ge;

    // numerator bits first, then the fraction zeros
    assign w_in = (r_cnt < DIV_CNT_W'(ACC_W)) ? r_num[ACC_W-1] : 1'b0;
    assign w_sh = {r_rem[ACC_W-2:0], w_in};
    assign w_ge = r_rem[ACC_W-1] || (w_sh >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[ACC_W-2:0], 1'b0};
            r_rem <= w_ge ? (w_sh - r_den) : w_sh;
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
            // quotient reached 2^32
            r_ovf <= r_ovf | r_quo[DATA_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

[hw/rtl/sds_dp.sv]
`default_nettype none

module sds_dp import sds_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic [IDX_W-1:0]         i_row,
    input  wire logic [IDX_W-1:0]         i_col,
    input  wire logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                      o_stat,
    output logic signed [DATA_W-1:0]      o_solution
);

    localparam logic signed [ACC_W-1:0]  SAT_HI = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0]  SAT_LO = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh80000000;

    typedef struct packed {
        logic             valid;
        t_phase           phase;
        logic [IDX_W-1:0] i;
        logic             first;
        logic             last;
    } t_tag;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_HI) begin
            res = Q_MAX;
        end else if (v < SAT_LO) begin
            res = Q_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    logic signed [DATA_W-1:0] r_mat [MAX_UNKNOWNS*MAX_UNKNOWNS];
    logic signed [DATA_W-1:0] r_rhs [MAX_UNKNOWNS];
    logic signed [DATA_W-1:0] r_x   [MAX_UNKNOWNS];
    logic signed [DATA_W-1:0] r_res [MAX_UNKNOWNS];
    logic signed [DATA_W-1:0] r_arv [MAX_UNKNOWNS];

    logic signed [DATA_W-1:0] r_mat_rd, r_rhs_rd, r_x_rd, r_res_rd, r_arv_rd;
    t_tag                     r_s1, r_s2, r_s3;
    logic signed [ACC_W-1:0]  r_p1, r_p2;
    logic signed [DATA_W-1:0] r_x_s2, r_b_s2, r_b_s3;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_den;
    logic [ACC_W-1:0]         r_rr;
    logic signed [DATA_W-1:0] r_alpha;
    logic signed [DATA_W-1:0] r_solution;

    t_tag                     w_tag;
    logic [IDX_W-1:0]         w_x_addr, w_r_addr;
    logic signed [DATA_W-1:0] w_ma, w_mb;
    logic signed [ACC_W-1:0]  w_p1, w_p2;
    logic [ACC_W:0]           w_rr_sum;
    logic signed [ACC_W-1:0]  w_x_sum;
    logic signed [DATA_W-1:0] w_x_new;
    logic signed [DATA_W-1:0] w_row_val;
    logic signed [DATA_W:0]   w_diff;
    logic                     w_row_end;
    logic [ACC_W-1:0]         w_den_mag;
    logic                     w_div_done, w_div_ovf;
    logic [DATA_W-1:0]        w_quo;

    assign w_tag.valid = i_cmd.valid && (i_cmd.phase == PH_MVX || i_cmd.phase == PH_MVR ||
                         i_cmd.phase == PH_DOT || i_cmd.phase == PH_UPD);
    assign w_tag.phase = i_cmd.phase;
    assign w_tag.i     = i_cmd.i;
    assign w_tag.first = i_cmd.first;
    assign w_tag.last  = i_cmd.last;

    assign w_x_addr = (i_cmd.phase == PH_MVX) ? i_cmd.j : i_cmd.i;
    assign w_r_addr = (i_cmd.phase == PH_MVR) ? i_cmd.j : i_cmd.i;

    // stores, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mat) begin
            r_mat[{i_row, i_col}] <= i_value;
        end
        r_mat_rd <= r_mat[{i_cmd.i, i_cmd.j}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_rhs) begin
            r_rhs[i_row] <= i_value;
        end
        r_rhs_rd <= r_rhs[i_cmd.i];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.phase == PH_CLR) begin
            r_x[i_cmd.i] <= '0;
        end else if (r_s2.valid && r_s2.phase == PH_UPD) begin
            r_x[r_s2.i] <= w_x_new;
        end
        r_x_rd <= r_x[w_x_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_row_end && r_s3.phase == PH_MVX) begin
            r_res[r_s3.i] <= w_diff > 33'sd2147483647 ? Q_MAX :
                             (w_diff < -33'sd2147483648 ? Q_MIN : w_diff[DATA_W-1:0]);
        end
        r_res_rd <= r_res[w_r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_row_end && r_s3.phase == PH_MVR) begin
            r_arv[r_s3.i] <= w_row_val;
        end
        r_arv_rd <= r_arv[i_cmd.i];
    end

    // stage tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else begin
            r_s1 <= w_tag;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_s1.phase)
            PH_MVX:  begin w_ma = r_mat_rd; w_mb = r_x_rd;   end
            PH_MVR:  begin w_ma = r_mat_rd; w_mb = r_res_rd; end
            PH_DOT:  begin w_ma = r_res_rd; w_mb = r_arv_rd; end
            PH_UPD:  begin w_ma = r_alpha;  w_mb = r_res_rd; end
            default: begin w_ma = r_mat_rd; w_mb = r_x_rd;   end
        endcase
    end

    assign w_p1 = w_ma * w_mb;
    assign w_p2 = r_res_rd * r_res_rd;

    always_ff @(posedge i_clk) begin
        r_p1   <= w_p1;
        r_p2   <= w_p2;
        r_x_s2 <= r_x_rd;
        r_b_s2 <= r_rhs_rd;
        r_b_s3 <= r_b_s2;
    end

    // accumulators
    assign w_rr_sum = {1'b0, r_rr} + {1'b0, r_p2};

    always_ff @(posedge i_clk) begin
        if (r_s2.valid && (r_s2.phase == PH_MVX || r_s2.phase == PH_MVR)) begin
            r_acc <= r_s2.first ? r_p1 : (r_acc + r_p1);
        end
        if (r_s2.valid && r_s2.phase == PH_DOT) begin
            r_den <= r_s2.first ? r_p1 : (r_den + r_p1);
            if (r_s2.first) begin
                r_rr <= r_p2;
            end else begin
                r_rr <= w_rr_sum[ACC_W] ? {ACC_W{1'b1}} : w_rr_sum[ACC_W-1:0];
            end
        end
    end

    // solution update
    assign w_x_sum = r_x_s2 + (r_p1 >>> FRAC_BITS);
    assign w_x_new = sat32(w_x_sum);

    // row results
    assign w_row_end = r_s3.valid && r_s3.last;
    assign w_row_val = sat32(r_acc >>> FRAC_BITS);
    assign w_diff    = r_b_s3 - w_row_val;

    // step size
    assign w_den_mag = r_den[ACC_W-1] ? (~r_den + 1'b1) : r_den;

    sds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (r_rr),
        .i_den   (w_den_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_ovf   (w_div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            if (r_den[ACC_W-1]) begin
                r_alpha <= (w_div_ovf || w_quo[DATA_W-1]) ? Q_MIN : $signed(~w_quo + 1'b1);
            end else begin
                r_alpha <= (w_div_ovf || w_quo[DATA_W-1]) ? Q_MAX : $signed(w_quo);
            end
        end
        if (i_cmd.load_out) begin
            r_solution <= r_x_rd;
        end
    end

    assign o_stat.den_zero  = (r_den == '0);
    assign o_stat.rr_le_tol = (r_rr <= {{(ACC_W-TOL_W){1'b0}}, i_cmd.tol});
    assign o_stat.div_done  = w_div_done;
    assign o_solution       = r_solution;

endmodule

`default_nettype wire

[hw/rtl/sds_ctrl.sv]
`default_nettype none

module sds_ctrl import sds_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic [1:0]           i_in_op,
    output logic                      o_in_ready,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TOL_W-1:0]     i_cfg_data,
    output logic                      o_cfg_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [IDX_W-1:0]          o_out_index,
    output logic                      o_out_last,
    output logic [STAT_W-1:0]         o_out_status,
    output logic [ITER_W-1:0]         o_out_iterations,
    output t_dp_cmd                   o_cmd,
    input  wire t_dp_stat             i_stat
);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [DRAIN_W-1:0]  r_cnt, n_cnt;
    logic [ITER_W-1:0]   r_iter, n_iter;
    t_status             r_status, n_status;
    logic [SIZE_W-1:0]   r_size;
    logic [ITER_W-1:0]   r_limit;
    logic [TOL_W-1:0]    r_tol;

    logic [SIZE_W-1:0]   w_n;
    logic [IDX_W-1:0]    w_nm1;
    logic [ITER_W-1:0]   w_limit;
    logic                w_i_end, w_j_end, w_drained;

    assign w_n = (r_size == '0) ? SIZE_W'(1) :
                 ((r_size > SIZE_W'(MAX_UNKNOWNS)) ? SIZE_W'(MAX_UNKNOWNS) : r_size);
    assign w_nm1     = IDX_W'(w_n - 1'b1);
    assign w_limit   = (r_limit == '0) ? ITER_W'(1) : r_limit;
    assign w_i_end   = (r_i == w_nm1);
    assign w_j_end   = (r_j == w_nm1);
    assign w_drained = (r_cnt == DRAIN_W'(DRAIN_CYC - 1));

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= SIZE_RESET;
            r_limit <= LIMIT_RESET;
            r_tol   <= TOL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE:  r_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[ITER_W-1:0];
                CFG_TOL:   r_tol   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_i      <= '0;
            r_j      <= '0;
            r_cnt    <= '0;
            r_iter   <= '0;
            r_status <= ST_CONV;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_cnt    <= n_cnt;
            r_iter   <= n_iter;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_iter      = r_iter;
        n_status    = r_status;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.tol   = r_tol;
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_op)
                        OP_WR_MAT: o_cmd.wr_mat = 1'b1;
                        OP_WR_RHS: o_cmd.wr_rhs = 1'b1;
                        OP_START: begin
                            n_state = S_CLR;
                            n_i     = '0;
                            n_j     = '0;
                            n_iter  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.valid = 1'b1;
                o_cmd.phase = PH_CLR;
                n_i = r_i + 1'b1;
                if (w_i_end) begin
                    n_i     = '0;
                    n_state = S_MVX;
                end
            end
            S_MVX, S_MVR: begin
                o_cmd.valid = 1'b1;
                o_cmd.phase = (r_state == S_MVX) ? PH_MVX : PH_MVR;
                o_cmd.first = (r_j == '0);
                o_cmd.last  = w_j_end;
                n_j = r_j + 1'b1;
                if (w_j_end) begin
                    n_j = '0;
                    n_i = r_i + 1'b1;
                    if (w_i_end) begin
                        n_i     = '0;
                        n_cnt   = '0;
                        n_state = (r_state == S_MVX) ? S_DRX : S_DRR;
                    end
                end
            end
            S_DOT, S_UPD: begin
                o_cmd.valid = 1'b1;
                o_cmd.phase = (r_state == S_DOT) ? PH_DOT : PH_UPD;
                o_cmd.first = (r_i == '0);
                o_cmd.last  = w_i_end;
                n_i = r_i + 1'b1;
                if (w_i_end) begin
                    n_i     = '0;
                    n_cnt   = '0;
                    n_state = (r_state == S_DOT) ? S_DRD : S_DRU;
                end
            end
            S_DRX, S_DRR, S_DRD, S_DRU: begin
                n_cnt = r_cnt + 1'b1;
                if (w_drained) begin
                    unique case (r_state)
                        S_DRX:   n_state = S_MVR;
                        S_DRR:   n_state = S_DOT;
                        S_DRD:   n_state = S_CHK;
                        default: n_state = S_DEC;
                    endcase
                end
            end
            S_CHK: begin
                n_iter = r_iter + 1'b1;
                if (i_stat.den_zero) begin
                    n_status = i_stat.rr_le_tol ? ST_CONV : ST_BREAK;
                    n_i      = '0;
                    n_state  = S_EMRD;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_i     = '0;
                    n_state = S_UPD;
                end
            end
            S_DEC: begin
                n_i = '0;
                n_j = '0;
                if (i_stat.rr_le_tol) begin
                    n_status = ST_CONV;
                    n_state  = S_EMRD;
                end else if (r_iter >= w_limit) begin
                    n_status = ST_LIMIT;
                    n_state  = S_EMRD;
                end else begin
                    n_state = S_MVX;
                end
            end
            S_EMRD: begin
                o_cmd.valid = 1'b1;
                o_cmd.phase = PH_EMIT;
                n_state     = S_EMWT;
            end
            S_EMWT: begin
                o_cmd.load_out = 1'b1;
                n_state        = S_EMOUT;
            end
            S_EMOUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (w_i_end) begin
                        n_i     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_EMRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_index      = r_i;
    assign o_out_last       = w_i_end;
    assign o_out_status     = r_status;
    assign o_out_iterations = r_iter;

endmodule

`default_nettype wire

[hw/rtl/steepest_descent_solver.sv]
// loads: one matrix or rhs write transaction per cycle while idle
// solve: a clear pass over x, then per iteration two matrix-vector passes
//   through the single multiply-accumulate unit, one dot pass, a bit-serial
//   divider and one update pass; n = size_in_use
// results: n transactions, each read out through S_EMRD, S_EMWT and S_EMOUT; no new start until done
// reset: synchronous active-low; config back to 64 / 60000 / 1, matrix and rhs undefined
`default_nettype none

module steepest_descent_solver import sds_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sds_in_if.sink     i_in,
    sds_out_if.source  o_out,
    sds_cfg_if.sink    i_cfg
);

    // controller <-> datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller: config registers, sequencing of the descent phases, result emission
    sds_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_in_op          (i_in.op),
        .o_in_ready       (i_in.ready),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_cfg_ready      (i_cfg.ready),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_out_index      (o_out.index),
        .o_out_last       (o_out.last),
        .o_out_status     (o_out.status),
        .o_out_iterations (o_out.iterations),
        .o_cmd            (w_cmd),
        .i_stat           (w_stat)
    );

    // datapath: stores, multiply-accumulate pipeline, divider, output register
    sds_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_row      (i_in.row),
        .i_col      (i_in.col),
        .i_value    (i_in.value),
        .o_stat     (w_stat),
        .o_solution (o_out.solution)
    );

endmodule

`default_nettype wire

[hw/rtl/sds_chk.sv]
`default_nettype none
`include "steepest_descent_solver_defines.svh"

module sds_chk import sds_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic                     out_last,
    input wire logic [IDX_W-1:0]         out_index,
    input wire logic signed [DATA_W-1:0] out_solution
);

    // a stalled result holds
    `SDS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_index) && $stable(out_solution))
    // no input taken while a result is pending
    `SDS_ASSERT_SAME(a_no_in_while_out, out_valid, !in_ready)
    // more entries follow a non-last result
    `SDS_ASSERT_NEXT(a_more_follow, out_valid && out_ready && !out_last, !in_ready)
    // the last mark closes the run
    `SDS_ASSERT_NEXT(a_last_closes, out_valid && out_ready && out_last, !out_valid)

endmodule

bind steepest_descent_solver sds_chk u_sds_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_ready     (i_in.ready),
    .out_valid    (o_out.valid),
    .out_ready    (o_out.ready),
    .out_last     (o_out.last),
    .out_index    (o_out.index),
    .out_solution (o_out.solution)
);

`default_nettype wire
